// ===== design/dcc_mobile_packet_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// dcc packet decoder assertion macros
// shared concurrent check forms on clk with asynchronous reset
// ----------------------------------------------------------------------------
`ifndef DCC_MOBILE_PACKET_DECODER_CORE_MACROS_SVH
`define DCC_MOBILE_PACKET_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define DCC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc packet decoder package
// shared constants, register indexes and item structs
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam logic [7:0] CV_MARKER     = 8'h7C;
	localparam logic [7:0] INSTR_128STEP = 8'h3F;
	localparam logic [7:0] INSTR_F13_F20 = 8'hDE;
	localparam logic [7:0] INSTR_F21_F28 = 8'hDF;
	localparam logic [7:0] LONG_ADDR_MIN = 8'd192;
	localparam logic [7:0] LONG_ADDR_MAX = 8'd231;
	localparam logic [7:0] SHORT_ADDR_MIN = 8'd3;
	localparam logic [7:0] SHORT_ADDR_MAX = 8'd127;
	localparam logic [7:0] FACTORY_CV    = 8'd7;
	localparam logic [7:0] FACTORY_VALUE = 8'd8;

	localparam int unsigned FN_W      = 29;
	localparam int unsigned SPEED_W   = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_USE_LONG   = 3'd0,
		CFG_SHORT_ADDR = 3'd1,
		CFG_LONG_HIGH  = 3'd2,
		CFG_LONG_LOW   = 3'd3,
		CFG_CONSIST    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       use_long_address;
		logic [7:0] short_address_cv;
		logic [7:0] long_address_high_cv;
		logic [7:0] long_address_low_cv;
		logic [6:0] consist_address;
	} cfg_t;

	typedef struct packed {
		logic [2:0] packet_length;
		logic [7:0] fourth_byte;
		logic [7:0] third_byte;
		logic [7:0] second_byte;
		logic [7:0] first_byte;
	} pkt_t;

	typedef struct packed {
		logic              forward;
		logic [SPEED_W-1:0] speed_step;
		logic [FN_W-1:0]   function_bits;
	} loco_state_t;

	typedef struct packed {
		logic              address_matched;
		logic              forward;
		logic [SPEED_W-1:0] speed_step;
		logic [FN_W-1:0]   function_bits;
		logic              changed;
		logic              cv_write;
		logic [7:0]        cv_index;
		logic [7:0]        cv_value;
		logic              factory_reset;
	} result_t;

endpackage

// ===== design/dcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dcc configuration registers
// cv-style address registers written through a plain write port
// ----------------------------------------------------------------------------
module dcc_cfg_regs
	import dcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_long_address     <= 1'b0;
			cfg_q.short_address_cv     <= 8'd3;
			cfg_q.long_address_high_cv <= 8'd192;
			cfg_q.long_address_low_cv  <= 8'd0;
			cfg_q.consist_address      <= 7'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USE_LONG:   cfg_q.use_long_address     <= cfg_data[0];
				CFG_SHORT_ADDR: cfg_q.short_address_cv     <= cfg_data;
				CFG_LONG_HIGH:  cfg_q.long_address_high_cv <= cfg_data;
				CFG_LONG_LOW:   cfg_q.long_address_low_cv  <= cfg_data;
				CFG_CONSIST:    cfg_q.consist_address      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/dcc_pkt_dec.sv =====
// ----------------------------------------------------------------------------
// dcc packet decode
// address match, instruction decode and next locomotive state
// ----------------------------------------------------------------------------
module dcc_pkt_dec
	import dcc_pkg::*;
(
	input  pkt_t        pkt,
	input  cfg_t        cfg,
	input  loco_state_t cur,
	output loco_state_t nxt,
	output result_t     res
);

	logic       is_marker, is_long, is_short, matched, do_decode, factory;
	logic       short_ok, long_ok;
	logic [7:0] ins, data;
	logic [2:0] base_len;
	loco_state_t upd;

	always_comb begin
		is_marker = (pkt.first_byte == CV_MARKER);
		is_long   = (pkt.first_byte >= LONG_ADDR_MIN) && (pkt.first_byte <= LONG_ADDR_MAX);
		is_short  = !pkt.first_byte[7];
		short_ok  = !cfg.use_long_address && (cfg.short_address_cv >= SHORT_ADDR_MIN)
			&& (cfg.short_address_cv <= SHORT_ADDR_MAX);
		long_ok   = cfg.use_long_address && (cfg.long_address_high_cv >= LONG_ADDR_MIN)
			&& (cfg.long_address_high_cv <= LONG_ADDR_MAX);

		matched = 1'b0;
		if (!is_marker) begin
			if (is_short) begin
				matched = (pkt.first_byte == 8'd0)
					|| ((cfg.consist_address != 7'd0)
						&& (pkt.first_byte == {1'b0, cfg.consist_address}))
					|| (short_ok && (pkt.first_byte == cfg.short_address_cv));
			end else if (is_long) begin
				matched = long_ok && (pkt.first_byte == cfg.long_address_high_cv)
					&& (pkt.second_byte == cfg.long_address_low_cv);
			end
		end

		// instruction and data bytes move one place for the long form
		ins      = is_long ? pkt.third_byte : pkt.second_byte;
		data     = is_long ? pkt.fourth_byte : pkt.third_byte;
		base_len = is_long ? 3'd3 : 3'd2;
		do_decode = matched && (pkt.packet_length >= base_len);

		upd = cur;
		if (ins == INSTR_128STEP && pkt.packet_length == base_len + 3'd1) begin
			upd.speed_step = data[6:0];
			upd.forward    = data[7];
		end else if (ins[7:6] == 2'b01 && pkt.packet_length == base_len) begin
			upd.speed_step = {2'b00, ins[4:0]};
			upd.forward    = ins[5];
		end else if (ins[7:5] == 3'b100) begin
			upd.function_bits[0]   = ins[4];
			upd.function_bits[4:1] = ins[3:0];
		end else if (ins[7:4] == 4'b1011) begin
			upd.function_bits[8:5] = ins[3:0];
		end else if (ins[7:4] == 4'b1010) begin
			upd.function_bits[12:9] = ins[3:0];
		end else if (ins == INSTR_F13_F20 && pkt.packet_length >= base_len + 3'd1) begin
			upd.function_bits[20:13] = data;
		end else if (ins == INSTR_F21_F28 && pkt.packet_length >= base_len + 3'd1) begin
			upd.function_bits[28:21] = data;
		end

		nxt = do_decode ? upd : cur;

		factory = is_marker && (pkt.second_byte == FACTORY_CV)
			&& (pkt.third_byte == FACTORY_VALUE);

		res.address_matched = matched;
		res.forward         = nxt.forward;
		res.speed_step      = nxt.speed_step;
		res.function_bits   = nxt.function_bits;
		res.changed         = (nxt != cur);
		res.cv_write        = is_marker && !factory;
		res.cv_index        = (is_marker && !factory) ? pkt.second_byte : 8'd0;
		res.cv_value        = (is_marker && !factory) ? pkt.third_byte : 8'd0;
		res.factory_reset   = factory;
	end

endmodule

// ===== design/dcc_mobile_packet_decoder_core.sv =====
// ----------------------------------------------------------------------------
// dcc mobile packet decoder core
// Takes checked DCC packets on the s_ stream, one item per packet:
// tdata holds the first four packet bytes and the length without the check
// byte. Each item gives exactly one result item on the m_ stream with the
// address match flag, the stored direction, speed and functions F0..F28,
// a changed flag and CV write or factory reset requests.
// The address registers are set through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// From acceptance to m_tvalid an item passes one input register, then the
// decode and state update into the result register.
// One item per cycle unless m_tready stalls; the stored state updates at the edge
// the result register loads, so the next item sees it at once.
// Reset clears both stages, sets direction forward, speed and functions to
// zero and the address registers to their CV defaults.
// When m_tready is low the result holds, the input register still fills,
// and s_tready falls once both stages are full.
// ----------------------------------------------------------------------------
module dcc_mobile_packet_decoder_core
	import dcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_byte, second_byte, third_byte, fourth_byte, packet_length
	input  logic [39:0]           s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// address_matched, forward, speed_step, function_bits, changed,
	// cv_write, cv_index, cv_value, factory_reset
	output logic [63:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "dcc_mobile_packet_decoder_core_macros.svh"

	cfg_t        cfg;
	pkt_t        pkt_s1;
	logic        valid_s1;
	loco_state_t state_q, state_nxt;
	result_t     res, out_q;
	logic        out_valid_q;
	logic        advance;

	dcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dcc_pkt_dec u_dec (
		.pkt (pkt_s1),
		.cfg (cfg),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pkt_s1 <= pkt_t'(s_tdata[34:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.forward       <= 1'b1;
			state_q.speed_step    <= '0;
			state_q.function_bits <= '0;
			out_valid_q           <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.factory_reset, out_q.cv_value, out_q.cv_index,
		out_q.cv_write, out_q.changed, out_q.function_bits, out_q.speed_step,
		out_q.forward, out_q.address_matched};

	`DCC_ASSERT_IMPL(a_req_exclusive, out_valid_q, !(out_q.cv_write && out_q.factory_reset),
		"cv write and factory reset both requested")
	`DCC_ASSERT_IMPL(a_req_no_update, out_valid_q && (out_q.cv_write || out_q.factory_reset),
		!out_q.address_matched && !out_q.changed, "cv request item decoded as packet")
	`DCC_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q),
		"locomotive state moved without an item")
	`DCC_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !advance, valid_s1,
		"stalled item lost from input stage")
	`DCC_ASSERT_NEXT(a_result_matches_state, advance,
		out_q.function_bits == state_q.function_bits && out_q.forward == state_q.forward,
		"result does not show stored state")

endmodule

// ===== tb/dcc_mobile_packet_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// dcc mobile packet decoder core testbench
// Streams checked packets into the decoder and compares every result item
// with an independent decode of the same packet against tracked address
// registers and locomotive state, over several address settings and idle
// patterns on both streams.
// ----------------------------------------------------------------------------
module dcc_mobile_packet_decoder_core_test;
	import dcc_pkg::*;

	localparam logic [1:0] SPEED_28STEP = 2'b01;
	localparam logic [2:0] FN_F0_F4     = 3'b100;
	localparam logic [3:0] FN_F5_F8     = 4'b1011;
	localparam logic [3:0] FN_F9_F12    = 4'b1010;

	class packet_decode_tracker;
		cfg_t        cfg;
		loco_state_t loco;
		result_t     decoded_packets[$];
		int          mismatches;

		function new();
			cfg.use_long_address     = 1'b0;
			cfg.short_address_cv     = 8'd3;
			cfg.long_address_high_cv = 8'd192;
			cfg.long_address_low_cv  = 8'd0;
			cfg.consist_address      = 7'd0;
			loco.forward             = 1'b1;
			loco.speed_step          = '0;
			loco.function_bits       = '0;
			mismatches               = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [7:0] value);
			case (idx)
				CFG_USE_LONG:   cfg.use_long_address     = value[0];
				CFG_SHORT_ADDR: cfg.short_address_cv     = value;
				CFG_LONG_HIGH:  cfg.long_address_high_cv = value;
				CFG_LONG_LOW:   cfg.long_address_low_cv  = value;
				CFG_CONSIST:    cfg.consist_address      = value[6:0];
				default: ;
			endcase
		endfunction

		function void note_packet(pkt_t p);
			result_t     r;
			loco_state_t nxt;
			logic [7:0]  ins;
			logic [7:0]  arg;
			bit          lng;
			bit          hit;
			r = '0;
			hit = 1'b0;
			if (p.first_byte == CV_MARKER) begin
				if (p.second_byte == FACTORY_CV && p.third_byte == FACTORY_VALUE) begin
					r.factory_reset = 1'b1;
				end else begin
					r.cv_write = 1'b1;
					r.cv_index = p.second_byte;
					r.cv_value = p.third_byte;
				end
			end else begin
				lng = p.first_byte >= LONG_ADDR_MIN && p.first_byte <= LONG_ADDR_MAX;
				if (p.first_byte <= SHORT_ADDR_MAX) begin
					hit = p.first_byte == 8'd0
						|| (cfg.consist_address != 7'd0
							&& p.first_byte == {1'b0, cfg.consist_address})
						|| (!cfg.use_long_address && cfg.short_address_cv >= SHORT_ADDR_MIN
							&& cfg.short_address_cv <= SHORT_ADDR_MAX
							&& p.first_byte == cfg.short_address_cv);
				end else if (lng) begin
					hit = cfg.use_long_address && cfg.long_address_high_cv >= LONG_ADDR_MIN
						&& cfg.long_address_high_cv <= LONG_ADDR_MAX
						&& p.first_byte == cfg.long_address_high_cv
						&& p.second_byte == cfg.long_address_low_cv;
				end
				ins = lng ? p.third_byte : p.second_byte;
				arg = lng ? p.fourth_byte : p.third_byte;
				if (hit && p.packet_length >= 3'd2 + lng) begin
					nxt = loco;
					if (ins == INSTR_128STEP && p.packet_length == 3'd3 + lng) begin
						nxt.speed_step = arg[6:0];
						nxt.forward    = arg[7];
					end else if (ins[7:6] == SPEED_28STEP && p.packet_length == 3'd2 + lng) begin
						nxt.speed_step = {2'b00, ins[4:0]};
						nxt.forward    = ins[5];
					end else if (ins[7:5] == FN_F0_F4) begin
						nxt.function_bits[0]   = ins[4];
						nxt.function_bits[4:1] = ins[3:0];
					end else if (ins[7:4] == FN_F5_F8) begin
						nxt.function_bits[8:5] = ins[3:0];
					end else if (ins[7:4] == FN_F9_F12) begin
						nxt.function_bits[12:9] = ins[3:0];
					end else if (ins == INSTR_F13_F20 && p.packet_length >= 3'd3 + lng) begin
						nxt.function_bits[20:13] = arg;
					end else if (ins == INSTR_F21_F28 && p.packet_length >= 3'd3 + lng) begin
						nxt.function_bits[28:21] = arg;
					end
					r.changed = nxt != loco;
					loco = nxt;
				end
			end
			r.address_matched = hit;
			r.forward         = loco.forward;
			r.speed_step      = loco.speed_step;
			r.function_bits   = loco.function_bits;
			decoded_packets.push_back(r);
		endfunction

		function void check_result(logic [63:0] d);
			result_t got;
			result_t want;
			got.address_matched = d[0];
			got.forward         = d[1];
			got.speed_step      = d[8:2];
			got.function_bits   = d[37:9];
			got.changed         = d[38];
			got.cv_write        = d[39];
			got.cv_index        = d[47:40];
			got.cv_value        = d[55:48];
			got.factory_reset   = d[56];
			if (decoded_packets.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unrequested result item %h", d);
				return;
			end
			want = decoded_packets.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch expected: match %0b fwd %0b speed %0d fn %h chg %0b",
						want.address_matched, want.forward, want.speed_step,
						want.function_bits, want.changed);
					$display("    cvw %0b cv %0d val %0d frst %0b", want.cv_write,
						want.cv_index, want.cv_value, want.factory_reset);
					$display("  actual:   match %0b fwd %0b speed %0d fn %h chg %0b",
						got.address_matched, got.forward, got.speed_step,
						got.function_bits, got.changed);
					$display("    cvw %0b cv %0d val %0d frst %0b", got.cv_write,
						got.cv_index, got.cv_value, got.factory_reset);
				end
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [39:0]           s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [63:0]           m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int send_idle_pct = 0;
	int stall_pct     = 0;

	packet_decode_tracker tracker;

	dcc_mobile_packet_decoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic pkt_t pk(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [7:0] b3, logic [2:0] len);
		pkt_t p;
		p.first_byte    = b0;
		p.second_byte   = b1;
		p.third_byte    = b2;
		p.fourth_byte   = b3;
		p.packet_length = len;
		return p;
	endfunction

	function automatic pkt_t random_packet();
		pkt_t       p;
		logic [7:0] ins;
		bit         lng;
		int         sel;
		p.first_byte    = 8'($urandom);
		p.second_byte   = 8'($urandom);
		p.third_byte    = 8'($urandom);
		p.fourth_byte   = 8'($urandom);
		p.packet_length = 3'($urandom_range(6, 1));
		sel = $urandom_range(99);
		if (sel < 10)
			return p;
		if (sel < 16) begin
			p.first_byte = CV_MARKER;
			if (sel < 12) begin
				p.second_byte = FACTORY_CV;
				p.third_byte  = FACTORY_VALUE;
			end
			return p;
		end
		case ($urandom_range(9))
			0: p.first_byte = 8'd0;
			1, 2: p.first_byte = {1'b0, tracker.cfg.consist_address};
			3: p.first_byte = tracker.cfg.short_address_cv;
			default: begin
				if (tracker.cfg.use_long_address) begin
					p.first_byte  = tracker.cfg.long_address_high_cv;
					p.second_byte = tracker.cfg.long_address_low_cv;
				end else begin
					p.first_byte = tracker.cfg.short_address_cv;
				end
			end
		endcase
		lng = p.first_byte >= LONG_ADDR_MIN && p.first_byte <= LONG_ADDR_MAX;
		ins = 8'($urandom);
		case ($urandom_range(7))
			0: ins = INSTR_128STEP;
			1: ins[7:6] = SPEED_28STEP;
			2: ins[7:5] = FN_F0_F4;
			3: ins[7:4] = FN_F5_F8;
			4: ins[7:4] = FN_F9_F12;
			5: ins = INSTR_F13_F20;
			6: ins = INSTR_F21_F28;
			default: ;
		endcase
		if (lng)
			p.third_byte = ins;
		else
			p.second_byte = ins;
		if ($urandom_range(9) < 8) begin
			if (ins[7:6] == SPEED_28STEP)
				p.packet_length = 3'd2 + lng;
			else
				p.packet_length = 3'd3 + lng;
		end
		return p;
	endfunction

	task automatic send_packet(input pkt_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, p};
		do @(posedge clk); while (!s_tready);
		tracker.note_packet(p);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (tracker.decoded_packets.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	task automatic load_addresses(input logic use_long, input logic [7:0] short_cv,
		input logic [7:0] high_cv, input logic [7:0] low_cv, input logic [6:0] consist);
		wait_drained();
		write_reg(CFG_USE_LONG, {7'd0, use_long});
		write_reg(CFG_SHORT_ADDR, short_cv);
		write_reg(CFG_LONG_HIGH, high_cv);
		write_reg(CFG_LONG_LOW, low_cv);
		write_reg(CFG_CONSIST, {1'b0, consist});
		cfg_we <= 1'b0;
	endtask

	task automatic load_random_addresses();
		logic [7:0] short_cv;
		logic [7:0] high_cv;
		logic [6:0] consist;
		case ($urandom_range(5))
			0: short_cv = SHORT_ADDR_MIN;
			1: short_cv = SHORT_ADDR_MAX;
			2: short_cv = 8'($urandom);
			default: short_cv = 8'($urandom_range(127, 3));
		endcase
		case ($urandom_range(5))
			0: high_cv = LONG_ADDR_MIN;
			1: high_cv = LONG_ADDR_MAX;
			2: high_cv = 8'($urandom);
			default: high_cv = 8'($urandom_range(231, 192));
		endcase
		case ($urandom_range(3))
			0: consist = 7'd0;
			1: consist = 7'h7F;
			default: consist = 7'($urandom);
		endcase
		load_addresses(1'($urandom_range(1)), short_cv, high_cv, 8'($urandom), consist);
	endtask

	initial begin
		#4_000_000;
		$display("** dcc_mobile_packet_decoder_core: FAILED **");
		$finish;
	end

	initial begin
		int phase;
		int n;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// default short address 3
		send_packet(pk(8'd3, INSTR_128STEP, 8'hFF, 8'h00, 3'd3));
		send_packet(pk(8'd3, INSTR_128STEP, 8'h00, 8'h00, 3'd3));
		send_packet(pk(8'd3, INSTR_128STEP, 8'h80, 8'h00, 3'd4));
		send_packet(pk(8'd3, 8'h7F, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'h40, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'h5F, 8'h00, 8'h00, 3'd3));
		send_packet(pk(8'd3, 8'h9F, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'hBF, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'hAF, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, INSTR_F13_F20, 8'hFF, 8'h00, 3'd3));
		send_packet(pk(8'd3, INSTR_F21_F28, 8'hFF, 8'h00, 3'd3));
		send_packet(pk(8'd3, INSTR_F13_F20, 8'h55, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'h80, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd0, 8'h9F, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'h00, 8'h00, 8'h00, 3'd1));
		send_packet(pk(8'd4, 8'h9F, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd3, 8'hC0, 8'h00, 8'h00, 3'd2));
		send_packet(pk(CV_MARKER, FACTORY_CV, FACTORY_VALUE, 8'h00, 3'd3));
		send_packet(pk(CV_MARKER, 8'h11, 8'h22, 8'h00, 3'd1));
		send_packet(pk(8'd200, 8'd0, 8'h9F, 8'h00, 3'd3));
		send_packet(pk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6));
		send_packet(pk(8'h00, 8'h00, 8'h00, 8'h00, 3'd1));

		// long address at the top of its range, consist at its top
		load_addresses(1'b1, SHORT_ADDR_MAX, LONG_ADDR_MAX, 8'hFF, 7'h7F);
		send_packet(pk(LONG_ADDR_MAX, 8'hFF, INSTR_128STEP, 8'hAA, 3'd4));
		send_packet(pk(LONG_ADDR_MAX, 8'hFF, 8'h61, 8'h00, 3'd3));
		send_packet(pk(LONG_ADDR_MAX, 8'hFF, INSTR_F21_F28, 8'h0F, 3'd4));
		send_packet(pk(LONG_ADDR_MAX, 8'hFE, 8'h9F, 8'h00, 3'd3));
		send_packet(pk(8'd127, 8'h90, 8'h00, 8'h00, 3'd2));

		// no own address, consist only
		load_addresses(1'b0, 8'd0, 8'd0, 8'd0, 7'd5);
		send_packet(pk(8'd5, 8'h7F, 8'h00, 8'h00, 3'd2));
		send_packet(pk(8'd0, 8'h60, 8'h00, 8'h00, 3'd2));

		for (phase = 0; phase < 8; phase++) begin
			load_random_addresses();
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 50; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 50; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			for (n = 0; n < 84; n++) begin
				send_packet(random_packet());
				if ($urandom_range(99) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.decoded_packets.size() == 0)
			$display("** dcc_mobile_packet_decoder_core: PASSED **");
		else
			$display("** dcc_mobile_packet_decoder_core: FAILED **");
		$finish;
	end

endmodule
